[rtl/core/text_buffer_with_clipboard_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the text buffer with clipboard
// Immediate-implication and next-cycle-implication checks on a clock.
// ----------------------------------------------------------------------------
`ifndef TEXT_BUFFER_WITH_CLIPBOARD_TOP_ASSERT_SVH
`define TEXT_BUFFER_WITH_CLIPBOARD_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TBC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tbc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tbc assertion failed");

`endif

[rtl/core/tbc_pkg.sv]
// ----------------------------------------------------------------------------
// tbc_pkg
// Types and constants shared by the text buffer with clipboard.
// ----------------------------------------------------------------------------
package tbc_pkg;

  // Store depth; a power of two so that address arithmetic wraps for free.
  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int LEN_W    = ADDR_W + 1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LEN_W-1:0]  len_t;

  localparam len_t CAP_LEN = len_t'(CAPACITY);

  typedef enum logic [2:0] {
    CMD_LEFT   = 3'd0,
    CMD_RIGHT  = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_CUT    = 3'd3,
    CMD_COPY   = 3'd4,
    CMD_PASTE  = 3'd5,
    CMD_READ   = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE,
    ST_COPY,
    ST_PASTE,
    ST_READ,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  char_in;
    logic [10:0] count;
    logic [9:0]  read_index;
  } req_t;

  typedef struct packed {
    logic [10:0] text_length;
    logic [10:0] cursor_position;
    logic [7:0]  read_char;
    logic        read_valid;
    logic        overflow;
  } rsp_t;

  typedef struct packed {
    logic       en;
    addr_t      addr;
    logic [7:0] data;
  } ram_wr_t;

endpackage

[rtl/core/tbc_if.sv]
// ----------------------------------------------------------------------------
// tbc channel interfaces
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface tbc_req_if;
  logic          valid;
  logic          ready;
  tbc_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tbc_rsp_if;
  logic          valid;
  logic          ready;
  tbc_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/tbc_ram.sv]
// ----------------------------------------------------------------------------
// tbc_ram
// Byte memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module tbc_ram (
  input  logic             clk,
  input  tbc_pkg::ram_wr_t wr,
  input  tbc_pkg::addr_t   raddr,
  output logic [7:0]       rdata
);

  logic [7:0] mem [tbc_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/text_buffer_with_clipboard_top.sv]
// Insert, blocked moves and unused codes go straight to the result stage; a
// cursor move or read first takes a memory read; cut/copy of k chars and
// paste of n chars move one character per cycle through the memory port.
// A new command is taken the cycle after its result is loaded into the output.
// Reset clears cursor, length, clipboard length and the output stage; the
// memories are not cleared, and no clearing pass runs.
// ----------------------------------------------------------------------------
// text_buffer_with_clipboard_top
// Gap-buffer text editor: text before the cursor sits at the bottom of the
// text memory, text after it at the top, with the free gap in between.
// ----------------------------------------------------------------------------
`include "text_buffer_with_clipboard_top_assert.svh"

module text_buffer_with_clipboard_top (
  input logic        clk,
  input logic        rst,
  tbc_req_if.sink    req,
  tbc_rsp_if.source  rsp
);

  tbc_pkg::state_e state, state_next;

  // Edit state. tail counts the characters after the cursor; they occupy
  // addresses CAPACITY - tail .. CAPACITY - 1 of the text memory.
  tbc_pkg::len_t cursor, cursor_next;
  tbc_pkg::len_t len, len_next;
  tbc_pkg::len_t clip_len, clip_len_next;
  tbc_pkg::len_t tail;

  // Block-transfer loop: j issues reads, lim is the character count.
  tbc_pkg::len_t j, j_next;
  tbc_pkg::len_t lim, lim_next;
  logic [2:0]    op, op_next;

  // Result fields gathered while the command runs.
  logic [7:0] rchar, rchar_next;
  logic       rvalid, rvalid_next;
  logic       ovf, ovf_next;

  logic          rsp_valid, rsp_valid_next;
  tbc_pkg::rsp_t rsp_data, rsp_data_next;

  // Memory ports.
  tbc_pkg::ram_wr_t text_wr, clip_wr;
  tbc_pkg::addr_t   text_raddr, clip_raddr;
  logic [7:0]       text_rdata, clip_rdata;

  tbc_pkg::len_t req_count, req_ridx, room, take;

  tbc_ram u_text_ram (
    .clk   (clk),
    .wr    (text_wr),
    .raddr (text_raddr),
    .rdata (text_rdata)
  );

  tbc_ram u_clip_ram (
    .clk   (clk),
    .wr    (clip_wr),
    .raddr (clip_raddr),
    .rdata (clip_rdata)
  );

  assign tail      = len - cursor;
  assign req_count = req.data.count;
  assign req_ridx  = tbc_pkg::len_t'(req.data.read_index);
  assign room      = tbc_pkg::CAP_LEN - len;
  // Characters a cut or copy can take: count clipped to the tail.
  assign take      = (req_count < tail) ? req_count : tail;

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  always_comb begin
    state_next     = state;
    cursor_next    = cursor;
    len_next       = len;
    clip_len_next  = clip_len;
    j_next         = j;
    lim_next       = lim;
    op_next        = op;
    rchar_next     = rchar;
    rvalid_next    = rvalid;
    ovf_next       = ovf;
    rsp_data_next  = rsp_data;
    rsp_valid_next = rsp_valid && !rsp.ready;
    req.ready      = 1'b0;
    text_wr        = '0;
    clip_wr        = '0;
    text_raddr     = '0;
    clip_raddr     = '0;

    case (state)
      tbc_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          op_next     = req.data.cmd;
          j_next      = '0;
          rchar_next  = '0;
          rvalid_next = 1'b0;
          ovf_next    = 1'b0;
          state_next  = tbc_pkg::ST_DONE;
          case (req.data.cmd)
            tbc_pkg::CMD_LEFT: begin
              // Fetch the char just before the cursor; it crosses the gap.
              text_raddr = tbc_pkg::addr_t'(cursor - 1'b1);
              if (cursor != '0) begin
                state_next = tbc_pkg::ST_MOVE;
              end
            end
            tbc_pkg::CMD_RIGHT: begin
              // Fetch the first char after the cursor.
              text_raddr = tbc_pkg::addr_t'(tbc_pkg::CAP_LEN - tail);
              if (tail != '0) begin
                state_next = tbc_pkg::ST_MOVE;
              end
            end
            tbc_pkg::CMD_INSERT: begin
              if (len != tbc_pkg::CAP_LEN) begin
                text_wr.en   = 1'b1;
                text_wr.addr = tbc_pkg::addr_t'(cursor);
                text_wr.data = req.data.char_in;
                cursor_next  = cursor + 1'b1;
                len_next     = len + 1'b1;
              end else begin
                ovf_next = 1'b1;
              end
            end
            tbc_pkg::CMD_CUT, tbc_pkg::CMD_COPY: begin
              // Clipboard is replaced even when nothing is taken.
              lim_next      = take;
              clip_len_next = take;
              state_next    = tbc_pkg::ST_COPY;
            end
            tbc_pkg::CMD_PASTE: begin
              // Paste only what fits in the gap; flag the rest as dropped.
              lim_next   = (clip_len < room) ? clip_len : room;
              ovf_next   = room < clip_len;
              state_next = tbc_pkg::ST_PASTE;
            end
            tbc_pkg::CMD_READ: begin
              // Positions at or past the cursor live above the gap.
              if (req_ridx < cursor) begin
                text_raddr = tbc_pkg::addr_t'(req_ridx);
              end else begin
                text_raddr = tbc_pkg::addr_t'(req_ridx - len);
              end
              rvalid_next = req_ridx < len;
              state_next  = tbc_pkg::ST_READ;
            end
            default: begin
              state_next = tbc_pkg::ST_DONE;
            end
          endcase
        end
      end

      tbc_pkg::ST_MOVE: begin
        // Drop the fetched char on the other side of the gap.
        text_wr.en   = 1'b1;
        text_wr.data = text_rdata;
        if (op == tbc_pkg::CMD_LEFT) begin
          text_wr.addr = tbc_pkg::addr_t'(tbc_pkg::CAP_LEN - tail - 1'b1);
          cursor_next  = cursor - 1'b1;
        end else begin
          text_wr.addr = tbc_pkg::addr_t'(cursor);
          cursor_next  = cursor + 1'b1;
        end
        state_next = tbc_pkg::ST_DONE;
      end

      tbc_pkg::ST_COPY: begin
        // Read tail char j while writing char j - 1 into the clipboard.
        text_raddr = tbc_pkg::addr_t'(tbc_pkg::CAP_LEN - tail + j);
        if (j != '0) begin
          clip_wr.en   = 1'b1;
          clip_wr.addr = tbc_pkg::addr_t'(j - 1'b1);
          clip_wr.data = text_rdata;
        end
        if (j == lim) begin
          // A cut just advances the start of the tail past the taken chars.
          if (op == tbc_pkg::CMD_CUT) begin
            len_next = len - lim;
          end
          state_next = tbc_pkg::ST_DONE;
        end else begin
          j_next = j + 1'b1;
        end
      end

      tbc_pkg::ST_PASTE: begin
        // Read clipboard char j while writing char j - 1 into the gap.
        clip_raddr = tbc_pkg::addr_t'(j);
        if (j != '0) begin
          text_wr.en   = 1'b1;
          text_wr.addr = tbc_pkg::addr_t'(cursor + j - 1'b1);
          text_wr.data = clip_rdata;
        end
        if (j == lim) begin
          cursor_next = cursor + lim;
          len_next    = len + lim;
          state_next  = tbc_pkg::ST_DONE;
        end else begin
          j_next = j + 1'b1;
        end
      end

      tbc_pkg::ST_READ: begin
        rchar_next = rvalid ? text_rdata : 8'd0;
        state_next = tbc_pkg::ST_DONE;
      end

      tbc_pkg::ST_DONE: begin
        // Load the output stage once it is free or being drained.
        if (!rsp_valid || rsp.ready) begin
          rsp_valid_next                = 1'b1;
          rsp_data_next.text_length     = len;
          rsp_data_next.cursor_position = cursor;
          rsp_data_next.read_char       = rchar;
          rsp_data_next.read_valid      = rvalid;
          rsp_data_next.overflow        = ovf;
          state_next                    = tbc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = tbc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tbc_pkg::ST_IDLE;
      cursor    <= '0;
      len       <= '0;
      clip_len  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cursor    <= cursor_next;
      len       <= len_next;
      clip_len  <= clip_len_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    j        <= j_next;
    lim      <= lim_next;
    op       <= op_next;
    rchar    <= rchar_next;
    rvalid   <= rvalid_next;
    ovf      <= ovf_next;
    rsp_data <= rsp_data_next;
  end

  `TBC_ASSERT_IMPL(a_cursor_in_text, clk, rst, 1'b1, cursor <= len)
  `TBC_ASSERT_IMPL(a_len_in_range, clk, rst, 1'b1, len <= tbc_pkg::CAP_LEN)
  `TBC_ASSERT_IMPL(a_clip_in_range, clk, rst, 1'b1, clip_len <= tbc_pkg::CAP_LEN)
  `TBC_ASSERT_IMPL(a_loop_bound, clk, rst,
                   state == tbc_pkg::ST_COPY || state == tbc_pkg::ST_PASTE, j <= lim)
  `TBC_ASSERT_NEXT(a_busy_after_take, clk, rst,
                   req.valid && req.ready, state != tbc_pkg::ST_IDLE)

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// Testbench for text_buffer_with_clipboard_top
// Drives editing commands over the command channel and checks every result
// against a cycle-free model of the text, cursor and clipboard, with random
// stalls on both channels and one long result back-pressure stretch.
// ----------------------------------------------------------------------------

// Mirror of the editor state; predicts one result per accepted command and
// checks results in order.
class editor_scoreboard;
  logic [7:0] text_mem [tbc_pkg::CAPACITY];
  logic [7:0] clip_mem [tbc_pkg::CAPACITY];
  int cursor;
  int length;
  int clip_len;
  tbc_pkg::rsp_t due_results [$];
  int mismatches;
  int results_seen;
  int valid_reads;
  int overflows;
  int peak_length;

  function new();
    cursor       = 0;
    length       = 0;
    clip_len     = 0;
    mismatches   = 0;
    results_seen = 0;
    valid_reads  = 0;
    overflows    = 0;
    peak_length  = 0;
  endfunction

  function void note_command(tbc_pkg::req_t item);
    tbc_pkg::rsp_t res;
    int take;
    int fit;
    int i;
    res = '0;
    case (item.cmd)
      tbc_pkg::CMD_LEFT: if (cursor > 0) cursor--;
      tbc_pkg::CMD_RIGHT: if (cursor < length) cursor++;
      tbc_pkg::CMD_INSERT: begin
        if (length < tbc_pkg::CAPACITY) begin
          for (i = length; i > cursor; i--) text_mem[i] = text_mem[i - 1];
          text_mem[cursor] = item.char_in;
          length++;
          cursor++;
        end else begin
          res.overflow = 1'b1;
        end
      end
      tbc_pkg::CMD_CUT, tbc_pkg::CMD_COPY: begin
        take = item.count;
        if (take > length - cursor) take = length - cursor;
        for (i = 0; i < take; i++) clip_mem[i] = text_mem[cursor + i];
        clip_len = take;
        if (item.cmd == tbc_pkg::CMD_CUT) begin
          for (i = cursor; i + take < length; i++) text_mem[i] = text_mem[i + take];
          length -= take;
        end
      end
      tbc_pkg::CMD_PASTE: begin
        fit = tbc_pkg::CAPACITY - length;
        if (fit > clip_len) fit = clip_len;
        if (fit < clip_len) res.overflow = 1'b1;
        for (i = length - 1; i >= cursor; i--) text_mem[i + fit] = text_mem[i];
        for (i = 0; i < fit; i++) text_mem[cursor + i] = clip_mem[i];
        length += fit;
        cursor += fit;
      end
      tbc_pkg::CMD_READ: begin
        if (item.read_index < length) begin
          res.read_char  = text_mem[item.read_index];
          res.read_valid = 1'b1;
        end
      end
      default: ;
    endcase
    res.text_length     = 11'(length);
    res.cursor_position = 11'(cursor);
    due_results.push_back(res);
  endfunction

  function void compare_field(string field, logic [10:0] want, logic [10:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  function void check_result(tbc_pkg::rsp_t got);
    tbc_pkg::rsp_t want;
    if (due_results.size() == 0) begin
      $error("result with no command pending: length %0d, cursor %0d",
             got.text_length, got.cursor_position);
      mismatches++;
      return;
    end
    want = due_results.pop_front();
    results_seen++;
    compare_field("text_length", want.text_length, got.text_length);
    compare_field("cursor_position", want.cursor_position, got.cursor_position);
    compare_field("read_char", want.read_char, got.read_char);
    compare_field("read_valid", want.read_valid, got.read_valid);
    compare_field("overflow", want.overflow, got.overflow);
    if (want.read_valid) valid_reads++;
    if (want.overflow) overflows++;
    if (want.text_length > peak_length) peak_length = want.text_length;
  endfunction
endclass

module tb;

  // cmd code the block must treat as a no-op
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  localparam int TOTAL_CMDS       = 1050;
  localparam int FILL_AT          = 650;   // switch to near-full editing here
  localparam int PHASE_LEN        = 350;   // commands per idling phase
  localparam int LONG_HOLD_AT     = 120;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES     = 1200;  // beyond the longest paste latency
  // Every command a full-length paste under the heaviest stalls stays far below.
  localparam int CYCLE_LIMIT      = 5000000;

  // Idle percentages per phase: receiver lazy, then sender lazy, then neither.
  localparam int SEND_IDLE_PCT [3] = '{18, 85, 0};
  localparam int RECV_IDLE_PCT [3] = '{85, 18, 0};

  logic clk;
  logic rst;

  tbc_req_if cmd_ch ();
  tbc_rsp_if res_ch ();

  text_buffer_with_clipboard_top dut (
    .clk (clk),
    .rst (rst),
    .req (cmd_ch),
    .rsp (res_ch)
  );

  editor_scoreboard board = new();

  int accepted_cmds = 0;
  int idle_phase    = 0;
  int cycle_count   = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Command side
  // ------------------------------------------------------------------------

  // Offer one command, idling first at the phase rate; return at the edge of
  // its transfer, with valid still high so back-to-back commands keep it up.
  task automatic send_command(input tbc_pkg::req_t item);
    while ($urandom_range(99) < SEND_IDLE_PCT[idle_phase]) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= item;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    board.note_command(item);
    accepted_cmds++;
    idle_phase = (accepted_cmds < PHASE_LEN) ? 0 :
                 (accepted_cmds < 2 * PHASE_LEN) ? 1 : 2;
  endtask

  task automatic issue_with(input logic [2:0] cmd, input logic [7:0] ch,
                            input logic [10:0] cnt, input logic [9:0] idx);
    tbc_pkg::req_t item;
    item.cmd        = cmd;
    item.char_in    = ch;
    item.count      = cnt;
    item.read_index = idx;
    send_command(item);
  endtask

  // Mostly short spans; clipping to the tail keeps the large ones cheap.
  function automatic logic [10:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 11'd0;
    if (r < 60) return 11'($urandom_range(1, 8));
    if (r < 85) return 11'($urandom_range(9, 64));
    if (r < 93) return 11'($urandom_range(65, 1022));
    return $urandom_range(1) ? 11'd1023 : 11'd1024;
  endfunction

  // Mostly inside the text, sometimes at the top index or anywhere.
  function automatic logic [9:0] pick_index();
    int r;
    r = $urandom_range(99);
    if (board.length > 0 && r < 75) return 10'($urandom_range(0, board.length - 1));
    if (r < 85) return 10'd1023;
    return 10'($urandom_range(0, 1023));
  endfunction

  // Unused fields carry random noise.
  task automatic issue(input logic [2:0] cmd);
    issue_with(cmd, 8'($urandom), pick_count(), pick_index());
  endtask

  // Short walk through the corner cases from an empty buffer.
  task automatic directed_cases();
    issue_with(tbc_pkg::CMD_LEFT, 8'h00, 11'd0, 10'd0);         // left at start
    issue_with(tbc_pkg::CMD_RIGHT, 8'hFF, 11'd1024, 10'd1023);  // right at end, empty
    issue_with(tbc_pkg::CMD_READ, 8'h00, 11'd0, 10'd0);         // read of empty text
    issue_with(tbc_pkg::CMD_CUT, 8'h00, 11'd5, 10'd0);          // count clipped to zero
    issue_with(tbc_pkg::CMD_PASTE, 8'h00, 11'd0, 10'd0);        // empty clipboard
    issue_with(tbc_pkg::CMD_INSERT, 8'h00, 11'd0, 10'd0);
    issue_with(tbc_pkg::CMD_INSERT, 8'hFF, 11'd0, 10'd0);
    issue_with(tbc_pkg::CMD_INSERT, 8'hA5, 11'd0, 10'd0);
    issue_with(tbc_pkg::CMD_INSERT, 8'h5A, 11'd0, 10'd0);
    issue_with(tbc_pkg::CMD_LEFT, 8'h00, 11'd0, 10'd0);
    issue_with(tbc_pkg::CMD_LEFT, 8'h00, 11'd0, 10'd0);
    issue_with(tbc_pkg::CMD_COPY, 8'h00, 11'd1024, 10'd0);      // count past the end
    issue_with(tbc_pkg::CMD_PASTE, 8'h00, 11'd0, 10'd0);        // paste mid-text
    issue_with(tbc_pkg::CMD_RIGHT, 8'h00, 11'd0, 10'd0);
    issue_with(tbc_pkg::CMD_RIGHT, 8'h00, 11'd0, 10'd0);
    issue_with(tbc_pkg::CMD_RIGHT, 8'h00, 11'd0, 10'd0);        // blocked at end
    issue_with(tbc_pkg::CMD_READ, 8'h00, 11'd0, 10'd0);
    issue_with(tbc_pkg::CMD_READ, 8'h00, 11'd0, 10'd5);
    issue_with(tbc_pkg::CMD_READ, 8'h00, 11'd0, 10'd6);         // one past the end
    issue_with(tbc_pkg::CMD_READ, 8'h00, 11'd0, 10'd1023);
    issue_with(tbc_pkg::CMD_LEFT, 8'h00, 11'd0, 10'd0);
    issue_with(tbc_pkg::CMD_CUT, 8'h00, 11'd0, 10'd0);          // zero count empties clipboard
    issue_with(tbc_pkg::CMD_CUT, 8'h00, 11'd1, 10'd0);
    issue_with(CMD_UNUSED, 8'hFF, 11'd2047, 10'd1023);          // no-op code
    issue_with(tbc_pkg::CMD_PASTE, 8'h00, 11'd0, 10'd0);
  endtask

  // Build a block, copy it, and paste until the text overflows: partial
  // paste, insert into full text, empty paste into full text.
  task automatic fill_to_brim();
    int span;
    span = $urandom_range(24, 40);
    repeat (span + $urandom_range(1, 7)) issue(tbc_pkg::CMD_INSERT);
    repeat (span) issue(tbc_pkg::CMD_LEFT);
    issue_with(tbc_pkg::CMD_COPY, 8'($urandom), 11'(span), 10'($urandom));
    while (board.length + span <= tbc_pkg::CAPACITY) issue(tbc_pkg::CMD_PASTE);
    if (board.length < tbc_pkg::CAPACITY) issue(tbc_pkg::CMD_PASTE);
    issue(tbc_pkg::CMD_INSERT);
    issue_with(tbc_pkg::CMD_COPY, 8'($urandom), 11'd0, 10'($urandom));
    issue(tbc_pkg::CMD_PASTE);
    issue_with(tbc_pkg::CMD_READ, 8'($urandom), 11'($urandom), 10'd1023);
  endtask

  // One random editing episode. With keep_short set, steer away from growth
  // once the text gets long so the early run explores small and mid lengths.
  task automatic edit_episode(input bit keep_short);
    int kind;
    logic [2:0] dir;
    kind = $urandom_range(0, 9);
    if (keep_short && board.length > 450 && (kind == 3 || kind == 9)) kind = 8;
    case (kind)
      0, 1: issue(3'($urandom_range(0, 7)));
      2: begin
        dir = $urandom_range(1) ? tbc_pkg::CMD_LEFT : tbc_pkg::CMD_RIGHT;
        repeat ($urandom_range(1, 24)) issue(dir);
      end
      3: repeat ($urandom_range(1, 12)) issue(tbc_pkg::CMD_INSERT);
      4, 5: begin
        issue(kind == 4 ? tbc_pkg::CMD_CUT : tbc_pkg::CMD_COPY);
        repeat ($urandom_range(0, 3)) begin
          issue($urandom_range(1) ? tbc_pkg::CMD_LEFT : tbc_pkg::CMD_RIGHT);
        end
        repeat ($urandom_range(1, 3)) begin
          if (!keep_short || board.length + board.clip_len <= 500) begin
            issue(tbc_pkg::CMD_PASTE);
          end
        end
      end
      6, 7: repeat ($urandom_range(1, 6)) issue(tbc_pkg::CMD_READ);
      8: begin
        // back off and drop the tail
        repeat ($urandom_range(1, 40)) issue(tbc_pkg::CMD_LEFT);
        issue_with(tbc_pkg::CMD_CUT, 8'($urandom), 11'd1024, 10'($urandom));
      end
      default: repeat ($urandom_range(2, 10)) begin
        issue($urandom_range(0, 2) != 0 ? tbc_pkg::CMD_INSERT : tbc_pkg::CMD_READ);
      end
    endcase
  endtask

  initial begin
    rst          <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.data  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    directed_cases();
    while (accepted_cmds < FILL_AT) edit_episode(1'b1);
    fill_to_brim();
    while (accepted_cmds < TOTAL_CMDS) edit_episode(1'b0);
    cmd_ch.valid <= 1'b0;

    // Wait out every pending result, then watch for strays.
    while (board.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d commands and %0d results: %0d in-range reads,",
             accepted_cmds, board.results_seen, board.valid_reads);
    $display("%0d overflowing inserts or pastes, peak text length %0d of %0d.",
             board.overflows, board.peak_length, tbc_pkg::CAPACITY);
    if (board.mismatches == 0 && board.due_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // ------------------------------------------------------------------------
  // Result side
  // ------------------------------------------------------------------------

  // Check each result transfer; stall ready at the phase rate, and once hold
  // it low for a long stretch so the block backs up into the command channel.
  initial begin : result_sink
    int hold_left;
    bit long_hold_done;
    hold_left      = 0;
    long_hold_done = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) board.check_result(res_ch.data);
      if (!long_hold_done && accepted_cmds >= LONG_HOLD_AT) begin
        hold_left      = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= RECV_IDLE_PCT[idle_phase]);
      end
    end
  end

endmodule
